// File: rtl/core/hsl_pkg.sv
package hsl_pkg;

  // Sample and divider widths.
  localparam int SAMPLE_W   = 8;
  localparam int HUE_W      = 13;
  localparam int FRAC_W     = 16;
  localparam int DIVIDEND_W = 25;
  localparam int DIVISOR_W  = 9;
  localparam int QUO_W      = 16;
  localparam int NUM_W      = SAMPLE_W + 3;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE_RESET = 8'd255;
  localparam logic [QUO_W-1:0]    HUE_WRAP         = 16'd5760;

  // Per-item flags that travel beside the dividers.
  typedef struct packed {
    logic valid;
    logic null_px;
    logic row_end;
    logic undef;
  } side_t;

  // Everything the front end hands to the dividers.
  typedef struct packed {
    side_t                 side;
    logic [DIVIDEND_W-1:0] light_num;
    logic [DIVISOR_W-1:0]  light_den;
    logic [DIVIDEND_W-1:0] sat_num;
    logic [DIVISOR_W-1:0]  sat_den;
    logic [DIVIDEND_W-1:0] hue_num;
    logic [DIVISOR_W-1:0]  hue_den;
  } front_t;

endpackage

// File: rtl/core/hsl_front.sv
module hsl_front
  import hsl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [SAMPLE_W-1:0] red,
  input  logic [SAMPLE_W-1:0] green,
  input  logic [SAMPLE_W-1:0] blue,
  input  logic                is_null,
  input  logic                row_end,
  input  logic [SAMPLE_W-1:0] full_scale,
  output front_t              front
);

  logic [SAMPLE_W-1:0] fs_eff, r_c, g_c, b_c, mx_c, mn_c;
  logic [SAMPLE_W-1:0] r1, g1, b1, mx1, mn1, fs1;
  logic                v1, null1, last1;
  logic [SAMPLE_W-1:0] c2;
  logic [SAMPLE_W:0]   sum2, den2;
  logic [NUM_W-1:0]    num2;
  front_t              front_next;

  // Stage one: limit the samples and find the extremes.
  always_comb begin
    fs_eff = (full_scale == '0) ? SAMPLE_W'(1) : full_scale;
    r_c = (red   > fs_eff) ? fs_eff : red;
    g_c = (green > fs_eff) ? fs_eff : green;
    b_c = (blue  > fs_eff) ? fs_eff : blue;
    mx_c = r_c;
    if (g_c > mx_c) mx_c = g_c;
    if (b_c > mx_c) mx_c = b_c;
    mn_c = r_c;
    if (g_c < mn_c) mn_c = g_c;
    if (b_c < mn_c) mn_c = b_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      r1 <= r_c; g1 <= g_c; b1 <= b_c;
      mx1 <= mx_c; mn1 <= mn_c; fs1 <= fs_eff;
      null1 <= is_null; last1 <= row_end;
    end
  end

  // Stage two: chroma, sums and the three dividends.
  always_comb begin
    c2   = mx1 - mn1;
    sum2 = {1'b0, mx1} + {1'b0, mn1};
    den2 = (sum2 <= {1'b0, fs1}) ? sum2 : ({fs1, 1'b0} - sum2);
    if (r1 == mx1) begin
      if (g1 >= b1) begin
        num2 = NUM_W'(g1 - b1);
      end else begin
        num2 = NUM_W'(6 * c2) - NUM_W'(b1 - g1);
      end
    end else if (g1 == mx1) begin
      num2 = NUM_W'(2 * c2) + NUM_W'(b1) - NUM_W'(r1);
    end else begin
      num2 = NUM_W'(4 * c2) + NUM_W'(r1) - NUM_W'(g1);
    end
    front_next.side.valid   = v1;
    front_next.side.null_px = null1;
    front_next.side.row_end = last1;
    front_next.side.undef   = (c2 == '0);
    front_next.light_num = (DIVIDEND_W'(sum2) << FRAC_W) - DIVIDEND_W'(sum2)
                           + DIVIDEND_W'(fs1);
    front_next.light_den = {fs1, 1'b0};
    front_next.sat_num   = (DIVIDEND_W'(c2) << FRAC_W) - DIVIDEND_W'(c2)
                           + DIVIDEND_W'(den2 >> 1);
    front_next.sat_den   = den2;
    front_next.hue_num   = (DIVIDEND_W'(num2) << 10) - (DIVIDEND_W'(num2) << 6)
                           + DIVIDEND_W'(c2 >> 1);
    front_next.hue_den   = DIVISOR_W'(c2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front.side.valid <= 1'b0;
    end else if (en) begin
      front.side.valid <= front_next.side.valid;
    end
    if (en) begin
      front.side.null_px <= front_next.side.null_px;
      front.side.row_end <= front_next.side.row_end;
      front.side.undef   <= front_next.side.undef;
      front.light_num <= front_next.light_num;
      front.light_den <= front_next.light_den;
      front.sat_num   <= front_next.sat_num;
      front.sat_den   <= front_next.sat_den;
      front.hue_num   <= front_next.hue_num;
      front.hue_den   <= front_next.hue_den;
    end
  end

endmodule

// File: rtl/core/hsl_div.sv
module hsl_div
  import hsl_pkg::*;
(
  input  logic                  clk,
  input  logic                  en,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [QUO_W-1:0]      quotient
);

  // One quotient bit per stage, restoring long division.
  logic [DIVISOR_W-1:0] rem [QUO_W];
  logic [QUO_W-1:0]     low [QUO_W];
  logic [QUO_W-1:0]     quo [QUO_W];
  logic [DIVISOR_W-1:0] dv  [QUO_W];
  logic [DIVISOR_W-1:0] rem_next [QUO_W];
  logic [QUO_W-1:0]     low_next [QUO_W];
  logic [QUO_W-1:0]     quo_next [QUO_W];
  logic [DIVISOR_W-1:0] dv_next  [QUO_W];

  always_comb begin
    logic [DIVISOR_W-1:0] cr, cd;
    logic [QUO_W-1:0]     cl, cq;
    logic [DIVISOR_W:0]   t;
    for (int k = 0; k < QUO_W; k++) begin
      if (k == 0) begin
        cr = dividend[DIVIDEND_W-1:QUO_W];
        cl = dividend[QUO_W-1:0];
        cq = '0;
        cd = divisor;
      end else begin
        cr = rem[k-1];
        cl = low[k-1];
        cq = quo[k-1];
        cd = dv[k-1];
      end
      t = {cr, cl[QUO_W-1]};
      if (t >= {1'b0, cd}) begin
        rem_next[k] = DIVISOR_W'(t - {1'b0, cd});
        quo_next[k] = {cq[QUO_W-2:0], 1'b1};
      end else begin
        rem_next[k] = t[DIVISOR_W-1:0];
        quo_next[k] = {cq[QUO_W-2:0], 1'b0};
      end
      low_next[k] = {cl[QUO_W-2:0], 1'b0};
      dv_next[k]  = cd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem <= rem_next;
      low <= low_next;
      quo <= quo_next;
      dv  <= dv_next;
    end
  end

  assign quotient = quo[QUO_W-1];

endmodule

// File: rtl/core/rgb_to_hsl_pixel.sv
// Pipeline: 2 front-end stages, 16 divider stages and 1 output register.
// Throughput: one item per cycle; the whole pipeline holds while the output is stalled.
// Reset (rst, synchronous, active high) clears all valid bits and sets
// full_scale to 255.
module rgb_to_hsl_pixel
  import hsl_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [23:0]         s_tdata,   // red, green, blue
  input  logic [0:0]          s_tuser,   // is_null
  input  logic                s_tlast,   // row_end
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [47:0]         m_tdata,   // hue, lightness, saturation, zero fill
  output logic [1:0]          m_tuser,   // hue_undefined, null_out
  output logic                m_tlast,   // row_end_out
  input  logic                cfg_we,
  input  logic [SAMPLE_W-1:0] cfg_wdata
);

  logic [SAMPLE_W-1:0] full_scale;
  logic                en;
  front_t              front;
  side_t               side [QUO_W];
  logic [QUO_W-1:0]    q_light, q_sat, q_hue;
  logic [QUO_W-1:0]    hue_wrapped;

  // The pipeline moves whenever the output register is free.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Full-scale register.
  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= FULL_SCALE_RESET;
    end else if (cfg_we) begin
      full_scale <= cfg_wdata;
    end
  end

  hsl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (s_tvalid),
    .red        (s_tdata[7:0]),
    .green      (s_tdata[15:8]),
    .blue       (s_tdata[23:16]),
    .is_null    (s_tuser[0]),
    .row_end    (s_tlast),
    .full_scale (full_scale),
    .front      (front)
  );

  hsl_div u_div_light (
    .clk (clk), .en (en),
    .dividend (front.light_num), .divisor (front.light_den), .quotient (q_light)
  );

  hsl_div u_div_sat (
    .clk (clk), .en (en),
    .dividend (front.sat_num), .divisor (front.sat_den), .quotient (q_sat)
  );

  hsl_div u_div_hue (
    .clk (clk), .en (en),
    .dividend (front.hue_num), .divisor (front.hue_den), .quotient (q_hue)
  );

  // Flags ride a shift line matched to the divider depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QUO_W; k++) begin
        side[k].valid <= 1'b0;
      end
    end else if (en) begin
      side[0].valid <= front.side.valid;
      for (int k = 1; k < QUO_W; k++) begin
        side[k].valid <= side[k-1].valid;
      end
    end
    if (en) begin
      side[0].null_px <= front.side.null_px;
      side[0].row_end <= front.side.row_end;
      side[0].undef   <= front.side.undef;
      for (int k = 1; k < QUO_W; k++) begin
        side[k].null_px <= side[k-1].null_px;
        side[k].row_end <= side[k-1].row_end;
        side[k].undef   <= side[k-1].undef;
      end
    end
  end

  assign hue_wrapped = (q_hue >= HUE_WRAP) ? (q_hue - HUE_WRAP) : q_hue;

  // Output register: wrap the hue and zero the fields of special pixels.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= side[QUO_W-1].valid;
    end
    if (en) begin
      m_tlast    <= side[QUO_W-1].row_end;
      m_tuser[1] <= side[QUO_W-1].null_px;
      m_tuser[0] <= side[QUO_W-1].undef && !side[QUO_W-1].null_px;
      m_tdata[47:45] <= '0;
      if (side[QUO_W-1].null_px) begin
        m_tdata[44:0] <= '0;
      end else if (side[QUO_W-1].undef) begin
        m_tdata[12:0]  <= '0;
        m_tdata[28:13] <= q_light;
        m_tdata[44:29] <= '0;
      end else begin
        m_tdata[12:0]  <= hue_wrapped[HUE_W-1:0];
        m_tdata[28:13] <= q_light;
        m_tdata[44:29] <= q_sat;
      end
    end
  end

endmodule

// File: rtl/core/hsl_chk.sv
module hsl_chk (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic [1:0]  m_tuser
);

  // No result comes out of a freshly reset pipeline.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // Null pixels carry zero fields and no undefined flag.
  a_null_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata[44:0] == '0 && !m_tuser[0])
    else $error("null result has nonzero fields");

  // Grey pixels report zero hue and saturation.
  a_grey_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[12:0] == '0 && m_tdata[44:29] == '0)
    else $error("grey result has hue or saturation");

  // Hue stays below a full turn.
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[12:0] < 13'd5760)
    else $error("hue out of range");

endmodule

bind rgb_to_hsl_pixel hsl_chk u_hsl_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
